// ----- design/pru_pkg.sv -----
`timescale 1ns / 1ps
// Package for the pixel replication upscaler: widths, register and opcode codes,
// and the structs passed between the sequencer, the row buffer and the top level.
// Depends on nothing.
package pru_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int PIXEL_W    = 24;
    localparam int SCALE_W    = 7;
    localparam int WIDTH_W    = 11;
    localparam int HEIGHT_W   = 16;
    localparam int PAD_W      = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [SCALE_W-1:0] SCALE_MAX = SCALE_W'(100);

    localparam logic [CFG_IDX_W-1:0] REG_SCALE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    // One access to the row buffer; a write and a read never share a cycle.
    typedef struct packed {
        logic               wr_en;
        logic               rd_en;
        logic [COL_W-1:0]   addr;
        logic [PIXEL_W-1:0] wdata;
    } pru_mem_req_t;

    // Result fields known when the word is accepted; the colour of a replayed
    // run comes later, from the registered read data of the row buffer.
    typedef struct packed {
        logic [PIXEL_W-1:0] colour;
        logic [SCALE_W-1:0] run_length;
        logic [PAD_W-1:0]   pad_bytes;
        logic               row_end;
        logic               frame_end;
        logic               rejected;
        logic               from_mem;
    } pru_res_t;

endpackage

// ----- design/pru_row_buf.sv -----
`timescale 1ns / 1ps
// Row buffer of the upscaler: one source row of pixels, one access per cycle,
// registered read data. Depends on pru_pkg.
module pru_row_buf (
    input  logic                          clk,
    input  pru_pkg::pru_mem_req_t         req,
    output logic [pru_pkg::PIXEL_W-1:0]   rd_data
);
    import pru_pkg::*;

    logic [PIXEL_W-1:0] mem [MAX_WIDTH];
    logic [PIXEL_W-1:0] rd_data_reg;

    // Read data only changes on a read, so it holds while the pipeline stalls.
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.addr] <= req.wdata;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- design/pru_seq.sv -----
`timescale 1ns / 1ps
// Sequencer of the upscaler: configuration registers, row and replay counters,
// row buffer requests and the result fields of each accepted word. Depends on pru_pkg.
module pru_seq (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [pru_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pru_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              take,
    input  logic                              opcode,
    input  logic [pru_pkg::PIXEL_W-1:0]       pixel,
    output pru_pkg::pru_mem_req_t             mem_req,
    output logic                              res_valid,
    output pru_pkg::pru_res_t                 res
);
    import pru_pkg::*;

    logic [SCALE_W-1:0]  scale_reg;
    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;

    logic [COL_W-1:0]    column_reg, column_next;
    logic [HEIGHT_W-1:0] source_row_reg, source_row_next;
    logic [SCALE_W-1:0]  copies_left_reg, copies_left_next;
    logic [COL_W-1:0]    replay_column_reg, replay_column_next;
    logic                replaying_reg, replaying_next;

    logic [SCALE_W-1:0]  s_eff;
    logic [COL_W-1:0]    w_last;
    logic [HEIGHT_W-1:0] h_last;
    logic                last_row;
    logic [PAD_W-1:0]    row_pad;
    logic [PAD_W-1:0]    bytes_lo;
    logic [HEIGHT_W-1:0] row_after;
    logic                pix_last;
    logic                rep_last;
    logic                final_copy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg  <= SCALE_W'(1);
            width_reg  <= WIDTH_W'(1);
            height_reg <= HEIGHT_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SCALE:  scale_reg  <= cfg_data[SCALE_W-1:0];
                REG_WIDTH:  width_reg  <= cfg_data[WIDTH_W-1:0];
                REG_HEIGHT: height_reg <= cfg_data[HEIGHT_W-1:0];
                default:    ;
            endcase
        end
    end

    // Out-of-range register values are clamped here.
    always_comb
    begin
        if (scale_reg == '0)
            s_eff = SCALE_W'(1);
        else if (scale_reg > SCALE_MAX)
            s_eff = SCALE_MAX;
        else
            s_eff = scale_reg;

        if (width_reg == '0)
            w_last = '0;
        else if (width_reg > WIDTH_W'(MAX_WIDTH))
            w_last = COL_W'(MAX_WIDTH - 1);
        else
            w_last = COL_W'(width_reg - WIDTH_W'(1));

        h_last = (height_reg == '0) ? '0 : height_reg - HEIGHT_W'(1);
    end

    assign last_row  = source_row_reg >= h_last;
    assign row_after = last_row ? '0 : source_row_reg + HEIGHT_W'(1);

    // Only the low two bits of width and scale matter for the padding mod 4.
    // The effective width is w_last + 1.
    assign bytes_lo = PAD_W'((w_last[PAD_W-1:0] + PAD_W'(1)) * s_eff[PAD_W-1:0] * PAD_W'(3));
    assign row_pad  = PAD_W'(0) - bytes_lo;

    assign pix_last   = column_reg >= w_last;
    assign rep_last   = replay_column_reg >= w_last;
    assign final_copy = copies_left_reg <= SCALE_W'(1);

    always_comb
    begin
        column_next        = column_reg;
        source_row_next    = source_row_reg;
        copies_left_next   = copies_left_reg;
        replay_column_next = replay_column_reg;
        replaying_next     = replaying_reg;
        mem_req            = '0;
        res_valid          = 1'b0;
        res                = '0;

        if (take)
        begin
            if (opcode == OP_PIXEL)
            begin
                res_valid = 1'b1;
                if (replaying_reg)
                begin
                    res.rejected = 1'b1;
                end
                else
                begin
                    mem_req.wr_en  = 1'b1;
                    mem_req.addr   = column_reg;
                    mem_req.wdata  = pixel;
                    res.colour     = pixel;
                    res.run_length = s_eff;
                    res.pad_bytes  = pix_last ? row_pad : '0;
                    res.row_end    = pix_last;
                    res.frame_end  = pix_last && (s_eff == SCALE_W'(1)) && last_row;
                    if (pix_last)
                    begin
                        column_next = '0;
                        if (s_eff > SCALE_W'(1))
                        begin
                            replaying_next     = 1'b1;
                            copies_left_next   = s_eff - SCALE_W'(1);
                            replay_column_next = '0;
                        end
                        else
                        begin
                            source_row_next = row_after;
                        end
                    end
                    else
                    begin
                        column_next = column_reg + COL_W'(1);
                    end
                end
            end
            else if (replaying_reg)
            begin
                res_valid      = 1'b1;
                mem_req.rd_en  = 1'b1;
                mem_req.addr   = replay_column_reg;
                res.from_mem   = 1'b1;
                res.run_length = s_eff;
                res.pad_bytes  = rep_last ? row_pad : '0;
                res.row_end    = rep_last;
                res.frame_end  = rep_last && final_copy && last_row;
                if (rep_last)
                begin
                    replay_column_next = '0;
                    if (final_copy)
                    begin
                        copies_left_next = '0;
                        replaying_next   = 1'b0;
                        source_row_next  = row_after;
                    end
                    else
                    begin
                        copies_left_next = copies_left_reg - SCALE_W'(1);
                    end
                end
                else
                begin
                    replay_column_next = replay_column_reg + COL_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg        <= '0;
            source_row_reg    <= '0;
            copies_left_reg   <= '0;
            replay_column_reg <= '0;
            replaying_reg     <= 1'b0;
        end
        else
        begin
            column_reg        <= column_next;
            source_row_reg    <= source_row_next;
            copies_left_reg   <= copies_left_next;
            replay_column_reg <= replay_column_next;
            replaying_reg     <= replaying_next;
        end
    end

endmodule

// ----- design/pixel_replication_upscaler_core.sv -----
`timescale 1ns / 1ps
// Top level of the integer nearest-neighbor pixel replication upscaler.
// Depends on pru_pkg, pru_seq and pru_row_buf.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+-------------------------------------------
//   input    | in_valid / in_stall       | opcode, pixel
//   output   | out_valid / out_stall     | colour, run_length, pad_bytes, row_end,
//            |                           | frame_end, rejected
//   config   | cfg_we (no wait)          | cfg_index, cfg_data
//
// One word is accepted per cycle while in_stall is low. The accepting edge also
// starts the row buffer read and loads the buffer stage; the output register is
// loaded from the buffer stage once it is empty or its word is taken. The single
// row buffer port, one write or one read per word, sets that rate.
// A write of a pixel and a later replay read of the same entry always fall on
// different clock edges, so the read sees the written value without forwarding.
// Reset clears the counters and sets scale, width and height to one; the row
// buffer is not cleared. A stalled output holds its word while one more result
// waits in the buffer stage; input stall rises only once both are full.
module pixel_replication_upscaler_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [pru_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pru_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              opcode,
    input  logic [pru_pkg::PIXEL_W-1:0]       pixel,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [pru_pkg::PIXEL_W-1:0]       colour,
    output logic [pru_pkg::SCALE_W-1:0]       run_length,
    output logic [pru_pkg::PAD_W-1:0]         pad_bytes,
    output logic                              row_end,
    output logic                              frame_end,
    output logic                              rejected
);
    import pru_pkg::*;

    pru_mem_req_t       mem_req;
    logic [PIXEL_W-1:0] rd_data;
    logic               take;
    logic               res_valid;
    pru_res_t           res;

    // Buffer stage: the word whose row buffer read is in flight.
    logic               s1_valid_reg;
    pru_res_t           s1_res_reg;

    // Output register.
    logic               out_valid_reg;
    pru_res_t           out_res_reg;
    logic [PIXEL_W-1:0] out_colour_reg;

    logic               out_load;
    logic               s1_free;

    assign out_load = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign s1_free  = !s1_valid_reg || out_load;
    assign in_stall = !s1_free;
    assign take     = in_valid && s1_free;

    pru_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .take      (take),
        .opcode    (opcode),
        .pixel     (pixel),
        .mem_req   (mem_req),
        .res_valid (res_valid),
        .res       (res)
    );

    pru_row_buf u_row_buf (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_free)
            begin
                s1_valid_reg <= res_valid;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers load without reset.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_res_reg <= res;
        end
        if (out_load)
        begin
            out_res_reg    <= s1_res_reg;
            out_colour_reg <= s1_res_reg.from_mem ? rd_data : s1_res_reg.colour;
        end
    end

    assign out_valid  = out_valid_reg;
    assign colour     = out_colour_reg;
    assign run_length = out_res_reg.run_length;
    assign pad_bytes  = out_res_reg.pad_bytes;
    assign row_end    = out_res_reg.row_end;
    assign frame_end  = out_res_reg.frame_end;
    assign rejected   = out_res_reg.rejected;

endmodule

// ----- bench/tb_pixel_replication_upscaler_core.sv -----
`timescale 1ns / 1ps
// Self-checking bench for pixel_replication_upscaler_core: random and directed pixel rows,
// replay ticks and register settings, checked run by run against a predictor in the bench.
// Depends on pru_pkg and the design files under design/.
module tb_pixel_replication_upscaler_core;

    import pru_pkg::*;

    // Drain time after the last predicted run, with margin for the output skid stage.
    localparam int DRAIN_CYCLES = 8;
    // Worst case is roughly 2000 words with sender gaps and receiver stall bursts,
    // plus one long receiver hold; this limit leaves a wide margin over that.
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_WORDS = 900;
    localparam int CALM_WORDS   = 150;

    // One output run as the block presents it.
    typedef struct packed {
        logic [PIXEL_W-1:0] colour;
        logic [SCALE_W-1:0] run_length;
        logic [PAD_W-1:0]   pad_bytes;
        logic               row_end;
        logic               frame_end;
        logic               rejected;
    } run_t;

    // The scoreboard keeps its own copy of the registers and of the sequencing state,
    // works out the run that each accepted word causes, and queues it for the check.
    class upscale_scoreboard;
        bit [SCALE_W-1:0]   scale_reg;
        bit [WIDTH_W-1:0]   width_reg;
        bit [HEIGHT_W-1:0]  height_reg;
        bit [PIXEL_W-1:0]   line_buf [MAX_WIDTH];
        bit                 line_written [MAX_WIDTH];
        int unsigned        column;
        int unsigned        source_row;
        int unsigned        copies_left;
        int unsigned        replay_column;
        bit                 replaying;
        run_t               pending_runs [$];
        int                 errors;

        function new();
            scale_reg     = 1;
            width_reg     = 1;
            height_reg    = 1;
            column        = 0;
            source_row    = 0;
            copies_left   = 0;
            replay_column = 0;
            replaying     = 0;
            errors        = 0;
            foreach (line_written[k])
            begin
                line_written[k] = 0;
                line_buf[k]     = '0;
            end
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
            if (index == REG_SCALE)
                scale_reg = value[SCALE_W-1:0];
            else if (index == REG_WIDTH)
                width_reg = value[WIDTH_W-1:0];
            else if (index == REG_HEIGHT)
                height_reg = value[HEIGHT_W-1:0];
        endfunction

        function int unsigned eff_scale();
            if (scale_reg == 0)
                return 1;
            if (scale_reg > SCALE_MAX)
                return SCALE_MAX;
            return scale_reg;
        endfunction

        function int unsigned eff_width();
            if (width_reg == 0)
                return 1;
            if (width_reg > MAX_WIDTH)
                return MAX_WIDTH;
            return width_reg;
        endfunction

        function int unsigned eff_height();
            return (height_reg == 0) ? 1 : height_reg;
        endfunction

        function int unsigned row_padding();
            return (4 - (eff_width() * eff_scale() * 3) % 4) % 4;
        endfunction

        function void next_source_row();
            if (source_row >= eff_height() - 1)
                source_row = 0;
            else
                source_row++;
        endfunction

        // A replay under a wider row must only read buffer entries that hold a pixel.
        function bit width_safe(int unsigned new_width);
            if (!replaying)
                return 1;
            for (int k = 0; k < new_width; k++)
            begin
                if (!line_written[k])
                    return 0;
            end
            return 1;
        endfunction

        function void accept_word(logic op, logic [PIXEL_W-1:0] px);
            int unsigned s;
            int unsigned w;
            int unsigned idx;
            bit          last_row;
            bit          last;
            bit          final_copy;
            run_t        run;
            s        = eff_scale();
            w        = eff_width();
            last_row = source_row >= eff_height() - 1;
            run      = '0;
            if (op == OP_PIXEL)
            begin
                if (replaying)
                begin
                    run.rejected = 1'b1;
                    pending_runs.push_back(run);
                    return;
                end
                if (column >= MAX_WIDTH)
                    column = MAX_WIDTH - 1;
                line_buf[column]     = px;
                line_written[column] = 1;
                last                 = column >= w - 1;
                run.colour           = px;
                run.run_length       = SCALE_W'(s);
                run.pad_bytes        = last ? PAD_W'(row_padding()) : '0;
                run.row_end          = last;
                run.frame_end        = last && s == 1 && last_row;
                pending_runs.push_back(run);
                if (last)
                begin
                    column = 0;
                    if (s > 1)
                    begin
                        replaying     = 1;
                        copies_left   = s - 1;
                        replay_column = 0;
                    end
                    else
                        next_source_row();
                end
                else
                    column++;
            end
            else if (replaying)
            begin
                idx            = (replay_column < MAX_WIDTH) ? replay_column : MAX_WIDTH - 1;
                last           = replay_column >= w - 1;
                final_copy     = copies_left <= 1;
                run.colour     = line_buf[idx];
                run.run_length = SCALE_W'(s);
                run.pad_bytes  = last ? PAD_W'(row_padding()) : '0;
                run.row_end    = last;
                run.frame_end  = last && final_copy && last_row;
                pending_runs.push_back(run);
                if (last)
                begin
                    replay_column = 0;
                    if (final_copy)
                    begin
                        copies_left = 0;
                        replaying   = 0;
                        next_source_row();
                    end
                    else
                        copies_left--;
                end
                else
                    replay_column++;
            end
        endfunction

        function void check_run(run_t seen);
            run_t want;
            if (pending_runs.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected run: colour %06h len %0d pad %0d row %0b frame %0b rej %0b",
                             seen.colour, seen.run_length, seen.pad_bytes, seen.row_end,
                             seen.frame_end, seen.rejected);
                return;
            end
            want = pending_runs.pop_front();
            if (seen.colour !== want.colour || seen.run_length !== want.run_length ||
                seen.pad_bytes !== want.pad_bytes || seen.row_end !== want.row_end ||
                seen.frame_end !== want.frame_end || seen.rejected !== want.rejected)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $display("run mismatch: expected colour %06h len %0d pad %0d row %0b frame %0b rej %0b",
                             want.colour, want.run_length, want.pad_bytes, want.row_end,
                             want.frame_end, want.rejected);
                    $display("                   got colour %06h len %0d pad %0d row %0b frame %0b rej %0b",
                             seen.colour, seen.run_length, seen.pad_bytes, seen.row_end,
                             seen.frame_end, seen.rejected);
                end
            end
        endfunction

        function int pending();
            return pending_runs.size();
        endfunction
    endclass

    // Every input of the block starts at a known value.
    logic                  clk        = 1'b0;
    logic                  rst_n      = 1'b0;
    logic                  cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index  = REG_SCALE;
    logic [CFG_DATA_W-1:0] cfg_data   = '0;
    logic                  in_valid   = 1'b0;
    logic                  opcode     = OP_PIXEL;
    logic [PIXEL_W-1:0]    pixel      = '0;
    logic                  out_stall  = 1'b0;
    logic                  in_stall;
    logic                  out_valid;
    logic [PIXEL_W-1:0]    colour;
    logic [SCALE_W-1:0]    run_length;
    logic [PAD_W-1:0]      pad_bytes;
    logic                  row_end;
    logic                  frame_end;
    logic                  rejected;

    upscale_scoreboard sb = new();

    // Words that cause a run; ticks outside replay are ignored by the block and not counted.
    int   words_done  = 0;
    int   cycle_count = 0;
    // In the closing part of the run neither side idles.
    bit   calm        = 0;
    // Set once by the stimulus to make the receiver hold off for a long stretch.
    bit   hold_req    = 0;
    int   hold_left   = 0;
    int   stall_left  = 0;
    run_t seen_run;

    pixel_replication_upscaler_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .opcode     (opcode),
        .pixel      (pixel),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .colour     (colour),
        .run_length (run_length),
        .pad_bytes  (pad_bytes),
        .row_end    (row_end),
        .frame_end  (frame_end),
        .rejected   (rejected)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Guard against a hung handshake.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Receiver: random stall bursts, quiet stretches between them,
    // and one long hold-off on request so that the block fills and stalls its input.
    always @(negedge clk)
    begin
        if (hold_req)
        begin
            hold_left = 80;
            hold_req  = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if (!calm && $urandom_range(0, 9) == 0)
        begin
            stall_left = $urandom_range(0, 5);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // Output monitor: every run taken at a rising edge is checked against the oldest
    // prediction. Sampling happens before the edge's register updates land.
    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            seen_run = '{colour, run_length, pad_bytes, row_end, frame_end, rejected};
            sb.check_run(seen_run);
        end
    end

    // Offer one word at the falling edge and hold it until the block takes it. The
    // prediction is made here, at the edge of acceptance, so the stimulus that follows
    // always sees the block's state as it now stands.
    task automatic send_word(logic op, logic [PIXEL_W-1:0] px);
        @(negedge clk);
        in_valid <= 1'b1;
        opcode   <= op;
        pixel    <= px;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        if (!(op == OP_TICK && !sb.replaying))
            words_done++;
        sb.accept_word(op, px);
    endtask

    // A sender gap, now and then.
    task automatic sender_gap();
        int n;
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            n = $urandom_range(1, 6);
            repeat (n)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
            end
        end
    endtask

    // Stop offering and wait until every predicted run is out, then give the block
    // time to finish any ignored tick still in its pipeline.
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        sb.set_reg(index, value);
    endtask

    // Program all three registers while the block is idle. The position counters are
    // kept across the write, so a wider row during replay would read buffer entries
    // that never held a pixel; in that case the replay is run out first.
    task automatic configure(int unsigned s, int unsigned w, int unsigned h);
        int unsigned new_width;
        new_width = (w == 0) ? 1 : (w > MAX_WIDTH) ? MAX_WIDTH : w;
        if (!sb.width_safe(new_width))
        begin
            while (sb.replaying)
                send_word(OP_TICK, PIXEL_W'($urandom));
            settle();
        end
        write_reg(REG_SCALE, CFG_DATA_W'(s));
        write_reg(REG_WIDTH, CFG_DATA_W'(w));
        write_reg(REG_HEIGHT, CFG_DATA_W'(h));
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Mostly well-formed traffic: pixels while the row is open, ticks while it is being
    // replayed, with a few stray ticks and a few pixels that arrive during replay.
    task automatic random_phase(int n);
        int               target;
        logic             op;
        logic [PIXEL_W-1:0] px;
        target = words_done + n;
        while (words_done < target)
        begin
            calm = words_done >= RANDOM_WORDS - CALM_WORDS;
            sender_gap();
            if (sb.replaying)
                op = ($urandom_range(0, 19) == 0) ? OP_PIXEL : OP_TICK;
            else
                op = ($urandom_range(0, 9) == 0) ? OP_TICK : OP_PIXEL;
            case ($urandom_range(0, 15))
                0:       px = '0;
                1:       px = '1;
                default: px = PIXEL_W'($urandom);
            endcase
            send_word(op, px);
        end
    endtask

    initial
    begin
        int          phase;
        int unsigned s;
        int unsigned w;
        int unsigned h;
        int          len;

        repeat (12)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part. Reset values give single-pixel rows that close the frame each time;
        // a tick outside replay must cause nothing.
        send_word(OP_PIXEL, 24'h000000);
        send_word(OP_PIXEL, 24'hFFFFFF);
        send_word(OP_TICK, 24'h5A5A5A);
        send_word(OP_PIXEL, 24'h123456);
        settle();

        // Zero in every register acts as one.
        configure(0, 0, 0);
        send_word(OP_PIXEL, 24'hA5A5A5);
        settle();

        // Two rows of two pixels at scale three: replay of each row, a pixel rejected
        // during replay, and the frame closing on the last replayed run.
        configure(3, 2, 2);
        send_word(OP_PIXEL, 24'h5A5A5A);
        send_word(OP_PIXEL, 24'h0F0F0F);
        send_word(OP_PIXEL, 24'h111111);
        repeat (4)
            send_word(OP_TICK, 24'h000000);
        send_word(OP_PIXEL, 24'h00FF00);
        send_word(OP_PIXEL, 24'hFF00FF);
        repeat (4)
            send_word(OP_TICK, 24'hFFFFFF);
        settle();

        // Random part, phase by phase. A few phases force the register extremes; the rest
        // keep rows short and scales small so that replays finish quickly.
        words_done = 0;
        phase      = 0;
        while (words_done < RANDOM_WORDS)
        begin
            len = $urandom_range(15, 60);
            case (phase)
                2:
                begin
                    // Scale above the maximum acts as one hundred.
                    s   = 127;
                    w   = 1;
                    h   = 2;
                    len = 210;
                end
                5:
                begin
                    // Width above the buffer size; the row is cut short by the next phase.
                    s = 1;
                    w = 2047;
                    h = 65535;
                end
                8:
                begin
                    s   = 100;
                    w   = 1;
                    h   = 1;
                    len = 110;
                end
                11:
                begin
                    s = 1;
                    w = MAX_WIDTH;
                    h = 1;
                end
                default:
                begin
                    case ($urandom_range(0, 9))
                        0:       s = 0;
                        8, 9:    s = $urandom_range(5, 12);
                        default: s = $urandom_range(1, 4);
                    endcase
                    case ($urandom_range(0, 9))
                        0:       w = 0;
                        8, 9:    w = $urandom_range(9, 40);
                        default: w = $urandom_range(1, 8);
                    endcase
                    case ($urandom_range(0, 9))
                        0:       h = 0;
                        9:       h = 65535;
                        default: h = $urandom_range(1, 3);
                    endcase
                end
            endcase
            configure(s, w, h);
            if (phase == 4)
                hold_req = 1;
            random_phase(len);
            // The sender pauses here until every run of the phase has come out.
            settle();
            phase++;
        end

        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- pixel_replication_upscaler_core.f -----
design/pru_pkg.sv
design/pru_row_buf.sv
design/pru_seq.sv
design/pixel_replication_upscaler_core.sv
bench/tb_pixel_replication_upscaler_core.sv
